// File: rtl/core/plh_pkg.sv
`timescale 1ns / 1ps

package plh_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned DEN_W      = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HITS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOPS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURNS  = 3'd4;

  // Register reset values
  localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 24'd5120;
  localparam logic [CNT_W-1:0]  HITS_RST     = 4'd4;
  localparam logic [CNT_W-1:0]  MISSES_RST   = 4'd5;
  localparam logic [CNT_W-1:0]  HOPS_RST     = 4'd6;
  localparam logic [CNT_W-1:0]  RETURNS_RST  = 4'd8;

  // Output field keeps 24 bits
  localparam logic [23:0] FIELD_MASK = 24'hFF_FFFF;

  // Harmonic number ceiling
  localparam logic [DEN_W-1:0] HARM_MAX = 8'hFF;
  localparam logic [DEN_W-1:0] DEN_ONE  = 8'd1;
  localparam logic [DEN_W-1:0] DEN_TWO  = 8'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_DIV,
    S_EVAL,
    S_TOL,
    S_PREP,
    S_QDIV,
    S_FINAL
  } state_e;

endpackage

// File: rtl/core/plh_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module plh_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   cand;
  logic             ge;

  // One shift-subtract step
  assign cand = {rem_q, quo_q[NUM_W-1]};
  assign ge   = cand >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d = CW'(NUM_W);
      quo_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
      quo_d  = {quo_q[NUM_W-2:0], ge};
      rem_d  = ge ? DEN_W'(cand - {1'b0, den_q}) : cand[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/core/pitch_lock_hysteresis_unit.sv
`timescale 1ns / 1ps

// Flow: the first item after reset goes straight to the final state; an estimate of zero or
//   one with nothing held skips the divisor tries; otherwise each try up to DIVISOR_LIMIT runs
//   the shared bit-serial divider, and a locked, related estimate runs it once more.
// Handshake: one item at a time; a new item is taken only in the idle state, which the
//   sequencer enters once the result is registered; a stalled result holds the sequencer.
// Reset: asynchronous, active low; registers return to their defaults, sequencer and lock state clear.
module pitch_lock_hysteresis_unit #(
  parameter int unsigned DIVISOR_LIMIT = 4,
  parameter int unsigned PITCH_WIDTH   = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [plh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [plh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [PITCH_WIDTH-1:0]         raw_pitch_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [PITCH_WIDTH-1:0]         locked_pitch_o,
  output logic                           is_locked_o
);

  localparam int unsigned PW   = PITCH_WIDTH;
  localparam int unsigned DW   = $clog2(DIVISOR_LIMIT + 1);
  localparam int unsigned NW   = PW + DW;
  localparam int unsigned MFW  = plh_pkg::FREQ_W + DW;
  localparam int unsigned CMPW = (MFW > PW) ? MFW : PW;
  localparam int unsigned FW   = plh_pkg::FREQ_W;
  localparam int unsigned KW   = plh_pkg::CNT_W;
  localparam int unsigned EW   = plh_pkg::DEN_W;

  // Configuration registers
  logic [FW-1:0] min_freq_q;
  logic [KW-1:0] hits_q, misses_q, hops_q, returns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q <= plh_pkg::MIN_FREQ_RST;
      hits_q     <= plh_pkg::HITS_RST;
      misses_q   <= plh_pkg::MISSES_RST;
      hops_q     <= plh_pkg::HOPS_RST;
      returns_q  <= plh_pkg::RETURNS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plh_pkg::CFG_MIN_FREQ: min_freq_q <= cfg_data_i[FW-1:0];
        plh_pkg::CFG_HITS:     hits_q     <= cfg_data_i[KW-1:0];
        plh_pkg::CFG_MISSES:   misses_q   <= cfg_data_i[KW-1:0];
        plh_pkg::CFG_HOPS:     hops_q     <= cfg_data_i[KW-1:0];
        plh_pkg::CFG_RETURNS:  returns_q  <= cfg_data_i[KW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and lock state
  plh_pkg::state_e state_q, state_d;
  logic           lock_q, lock_d;
  logic           primed_q, primed_d;
  logic [PW-1:0]  held_q, held_d;
  logic [KW-1:0]  hit_q, hit_d, hop_q, hop_d, ret_q, ret_d;
  logic [EW-1:0]  prev_nd_q, prev_nd_d, prev_hd_q, prev_hd_d;
  logic           out_valid_q, out_valid_d;
  logic [PW-1:0]  out_pitch_q, out_pitch_d;
  logic           out_lock_q, out_lock_d;

  // Per-item working registers
  logic [PW-1:0]  f_q, f_d;
  logic [PW-1:0]  small_q, small_d, big_q, big_d;
  logic           a_small_q, a_small_d;
  logic [DW-1:0]  d_q, d_d;
  logic [NW-1:0]  num_q, num_d;
  logic [MFW-1:0] mf_q, mf_d;
  logic [PW-1:0]  e_q, e_d;
  logic [EW-1:0]  n_q, n_d;
  logic           rel_q, rel_d;
  logic [EW-1:0]  nd_q, nd_d, hd_q, hd_d;

  // Shared divider
  logic           div_start;
  logic           div_q_sel;
  logic [NW-1:0]  div_num;
  logic [PW-1:0]  div_den;
  logic           div_done;
  logic [NW-1:0]  div_quo;
  logic [PW-1:0]  div_rem;

  assign div_num = div_q_sel ? NW'(f_q) : num_q;
  assign div_den = div_q_sel ? PW'(nd_q) : small_q;

  plh_div #(
    .NUM_W (NW),
    .DEN_W (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Operand ordering at accept
  logic           held_lt_raw;
  logic [PW-1:0]  small_c, big_c;

  assign held_lt_raw = held_q < raw_pitch_i;
  assign small_c     = held_lt_raw ? held_q : raw_pitch_i;
  assign big_c       = held_lt_raw ? raw_pitch_i : held_q;

  // Rounding to the nearest harmonic
  logic           round_up;
  logic           q_hi;
  logic [EW:0]    n9;
  logic [PW+4:0]  e20;
  logic           too_small;

  assign round_up  = {div_rem, 1'b0} >= {1'b0, small_q};
  assign q_hi      = |div_quo[NW-1:EW];
  assign n9        = {1'b0, div_quo[EW-1:0]} + (EW+1)'(round_up);
  // 20*e as 16*e + 4*e
  assign e20       = ({5'b0, e_q} << 4) + ({5'b0, e_q} << 2);
  assign too_small = CMPW'(mf_q) > CMPW'(small_q);

  // Decision terms
  logic [PW-1:0]  fq;
  logic [KW:0]    hit_inc, hop_inc, ret_inc;
  logic           rel_u;
  logic [EW-1:0]  nd_u, hd_u;
  logic           fail, half;
  logic [KW:0]    miss_val;
  logic           slot_free;
  logic [PW-1:0]  result;

  assign fq        = div_quo[PW-1:0];
  assign hit_inc   = {1'b0, hit_q} + (KW+1)'(1);
  assign hop_inc   = {1'b0, hop_q} + (KW+1)'(1);
  assign ret_inc   = {1'b0, ret_q} + (KW+1)'(1);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    lock_d      = lock_q;
    primed_d    = primed_q;
    held_d      = held_q;
    hit_d       = hit_q;
    hop_d       = hop_q;
    ret_d       = ret_q;
    prev_nd_d   = prev_nd_q;
    prev_hd_d   = prev_hd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pitch_d = out_pitch_q;
    out_lock_d  = out_lock_q;
    f_d         = f_q;
    small_d     = small_q;
    big_d       = big_q;
    a_small_d   = a_small_q;
    d_d         = d_q;
    num_d       = num_q;
    mf_d        = mf_q;
    e_d         = e_q;
    n_d         = n_q;
    rel_d       = rel_q;
    nd_d        = nd_q;
    hd_d        = hd_q;
    div_start   = 1'b0;
    div_q_sel   = 1'b0;
    rel_u       = rel_q;
    nd_u        = nd_q;
    hd_u        = hd_q;
    fail        = 1'b0;
    half        = 1'b0;
    miss_val    = '0;
    result      = '0;

    unique case (state_q)
      plh_pkg::S_IDLE: begin
        if (in_valid_i) begin
          f_d       = raw_pitch_i;
          small_d   = small_c;
          big_d     = big_c;
          a_small_d = !held_lt_raw;
          d_d       = DW'(1);
          num_d     = NW'(big_c);
          mf_d      = MFW'(min_freq_q);
          rel_d     = 1'b0;
          nd_d      = '0;
          hd_d      = '0;
          if (!primed_q) begin
            state_d = plh_pkg::S_FINAL;
          end else if (raw_pitch_i == '0 || held_q == '0) begin
            state_d = plh_pkg::S_PREP;
          end else begin
            state_d = plh_pkg::S_CHK;
          end
        end
      end

      // Divisor try: bail out once min_frequency*d passes the smaller pitch
      plh_pkg::S_CHK: begin
        if (too_small) begin
          state_d = plh_pkg::S_PREP;
        end else begin
          div_start = 1'b1;
          state_d   = plh_pkg::S_DIV;
        end
      end

      plh_pkg::S_DIV: begin
        if (div_done) begin
          state_d = plh_pkg::S_EVAL;
        end
      end

      // Nearest harmonic and its error, saturated at the top
      plh_pkg::S_EVAL: begin
        e_d     = round_up ? small_q - div_rem : div_rem;
        n_d     = (q_hi || n9[EW]) ? plh_pkg::HARM_MAX : n9[EW-1:0];
        state_d = plh_pkg::S_TOL;
      end

      plh_pkg::S_TOL: begin
        if (e20 < {5'b0, small_q}) begin
          rel_d   = 1'b1;
          nd_d    = a_small_q ? EW'(d_q) : n_q;
          hd_d    = a_small_q ? n_q : EW'(d_q);
          state_d = plh_pkg::S_PREP;
        end else if (d_q == DW'(DIVISOR_LIMIT)) begin
          state_d = plh_pkg::S_PREP;
        end else begin
          d_d     = d_q + DW'(1);
          num_d   = num_q + NW'(big_q);
          mf_d    = mf_q + MFW'(min_freq_q);
          state_d = plh_pkg::S_CHK;
        end
      end

      // Estimate over its denominator, needed only while locked
      plh_pkg::S_PREP: begin
        if (lock_q && rel_q) begin
          div_q_sel = 1'b1;
          div_start = 1'b1;
          state_d   = plh_pkg::S_QDIV;
        end else begin
          state_d = plh_pkg::S_FINAL;
        end
      end

      plh_pkg::S_QDIV: begin
        div_q_sel = 1'b1;
        if (div_done) begin
          state_d = plh_pkg::S_FINAL;
        end
      end

      plh_pkg::S_FINAL: begin
        div_q_sel = 1'b1;
        if (!primed_q) begin
          // First item only primes the unit and clears the held pitch, hit count and previous denominators
          primed_d  = 1'b1;
          held_d    = '0;
          hit_d     = '0;
          prev_nd_d = '0;
          prev_hd_d = '0;
        end else if (!lock_q) begin
          // Any nonzero pitch starts a run from an empty hold
          if (f_q != '0 && held_q == '0) begin
            rel_u = 1'b1;
            nd_u  = plh_pkg::DEN_ONE;
            hd_u  = plh_pkg::DEN_ONE;
          end
          if (rel_u && nd_u == plh_pkg::DEN_ONE && hd_u == plh_pkg::DEN_ONE) begin
            held_d = f_q;
            if (hit_inc >= {1'b0, hits_q}) begin
              lock_d = 1'b1;
              hit_d  = '0;
            end else begin
              hit_d = hit_inc[KW-1:0];
            end
          end else begin
            hit_d  = '0;
            held_d = '0;
          end
          prev_nd_d = nd_u;
          prev_hd_d = hd_u;
        end else begin
          if (rel_q) begin
            if (hd_q == plh_pkg::DEN_ONE) begin
              // Estimate is a harmonic of the hold
              result = fq;
              held_d = fq;
              hop_d  = '0;
              if (nd_q != plh_pkg::DEN_ONE && nd_q == prev_nd_q) begin
                if (ret_inc >= {1'b0, returns_q}) begin
                  result = f_q;
                  held_d = f_q;
                  ret_d  = '0;
                end else begin
                  ret_d = ret_inc[KW-1:0];
                end
              end else begin
                ret_d = '0;
              end
            end else begin
              // Estimate is not a whole multiple of the hold: count repeated hops
              ret_d = '0;
              half  = (hd_q == plh_pkg::DEN_TWO);
              fail  = 1'b1;
              if (CMPW'(fq) >= CMPW'(min_freq_q) && hd_q == prev_hd_q) begin
                if (hop_inc >= {1'b0, hops_q}) begin
                  result = fq;
                  held_d = fq;
                  hop_d  = '0;
                  fail   = 1'b0;
                end else begin
                  hop_d = hop_inc[KW-1:0];
                end
              end
            end
          end else begin
            fail = 1'b1;
          end
          // Misses; an estimate with a hold denominator of two keeps the count
          if (fail) begin
            result   = held_d;
            miss_val = half ? {1'b0, hit_q} : hit_inc;
            if (miss_val >= {1'b0, misses_q}) begin
              held_d = '0;
              lock_d = 1'b0;
              hit_d  = '0;
              result = '0;
            end else begin
              hit_d = miss_val[KW-1:0];
            end
          end else begin
            hit_d = '0;
          end
          prev_nd_d = nd_q;
          prev_hd_d = hd_q;
        end

        out_pitch_d = result & PW'(plh_pkg::FIELD_MASK);
        out_lock_d  = lock_d;

        // Commit only when the output register can take the item
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = plh_pkg::S_IDLE;
        end else begin
          lock_d      = lock_q;
          primed_d    = primed_q;
          held_d      = held_q;
          hit_d       = hit_q;
          hop_d       = hop_q;
          ret_d       = ret_q;
          prev_nd_d   = prev_nd_q;
          prev_hd_d   = prev_hd_q;
          out_pitch_d = out_pitch_q;
          out_lock_d  = out_lock_q;
        end
      end

      default: state_d = plh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plh_pkg::S_IDLE;
      lock_q      <= 1'b0;
      primed_q    <= 1'b0;
      held_q      <= '0;
      hit_q       <= '0;
      hop_q       <= '0;
      ret_q       <= '0;
      prev_nd_q   <= '0;
      prev_hd_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lock_q      <= lock_d;
      primed_q    <= primed_d;
      held_q      <= held_d;
      hit_q       <= hit_d;
      hop_q       <= hop_d;
      ret_q       <= ret_d;
      prev_nd_q   <= prev_nd_d;
      prev_hd_q   <= prev_hd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pitch_q <= out_pitch_d;
    out_lock_q  <= out_lock_d;
    f_q         <= f_d;
    small_q     <= small_d;
    big_q       <= big_d;
    a_small_q   <= a_small_d;
    d_q         <= d_d;
    num_q       <= num_d;
    mf_q        <= mf_d;
    e_q         <= e_d;
    n_q         <= n_d;
    rel_q       <= rel_d;
    nd_q        <= nd_d;
    hd_q        <= hd_d;
  end

  assign in_ready_o     = (state_q == plh_pkg::S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign locked_pitch_o = out_pitch_q;
  assign is_locked_o    = out_lock_q;

endmodule
